/* src/eopc_pkg.sv */
// ----------------------------------------------------------------------------
// eopc_pkg: shared types and constants for the polygon coverage block
// Holds the command and status codes, controller states, store geometry and
// the token that carries one stored vertex into the edge pipeline.
// ----------------------------------------------------------------------------
package eopc_pkg;

  localparam int MAX_VERT = 256;
  localparam int ADDR_W   = $clog2(MAX_VERT);
  localparam int CNT_W    = $clog2(MAX_VERT + 1);
  localparam int COORD_W  = 21;
  localparam int REG_W    = 9;
  localparam int PIX_W    = 8;
  localparam int SUB      = 4;
  localparam int NSAMP    = SUB * SUB;
  localparam int PROD_W   = 48;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_START = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NO_PATH = 2'd2,
    STAT_OFF     = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE,
    ST_DRAIN
  } state_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                      mark;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vert_t;

  typedef struct packed {
    logic  vld;
    logic  first;
    logic  close;
    vert_t v;
  } tok_t;

endpackage

/* src/eopc_if.sv */
// ----------------------------------------------------------------------------
// eopc_if: stream interfaces of the polygon coverage block
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface eopc_in_if;
  import eopc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [PIX_W-1:0]          pixel_col;
  logic [PIX_W-1:0]          pixel_row;

  modport source (output valid, command, point_x, point_y, pixel_col, pixel_row,
                  input ready);
  modport sink (input valid, command, point_x, point_y, pixel_col, pixel_row,
                output ready);
endinterface

interface eopc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic [1:0] status;

  modport source (output valid, alpha, status, input ready);
  modport sink (input valid, alpha, status, output ready);
endinterface

/* src/even_odd_polygon_coverage.sv */
// ----------------------------------------------------------------------------
// even_odd_polygon_coverage: even-odd polygon coverage, 4x4 supersampling
// Keeps polygon vertices in a store and answers pixel coverage queries.
//
//   Channel  Direction  Payload
//   in_ch    in         command, point_x, point_y, pixel_col, pixel_row
//   out_ch   out        alpha, status
//   cfg_*    in         register index and data, write only
//
// Clear, start and line commands are answered straight from the idle state,
// as are queries off the frame and queries on an empty store.
// For a query inside the frame on a nonempty store, the store is read one
// vertex a cycle and each edge passes a five-stage crossing pipeline.
// Reset clears the vertex count and subpath state; the store needs no sweep.
// A new transfer is taken while the previous result is being taken.
// ----------------------------------------------------------------------------
module even_odd_polygon_coverage
  import eopc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  eopc_in_if.sink          in_ch,
  eopc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             open_r, open_nxt;
  logic [REG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] col_r, row_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       alpha_r, alpha_nxt;
  stat_t            status_r, status_nxt;
  logic             rvld_r, rfirst_r, rclose_r;
  logic             rvld_nxt, rfirst_nxt, rclose_nxt;

  logic             take;
  logic             full;
  logic             we;
  logic             clr;
  vert_t            wdata, rdata;
  tok_t             tok;
  logic             busy;
  logic [NSAMP-1:0] cover_bits;
  logic [4:0]       ones;
  logic [12:0]      scaled;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_VERT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= REG_W'(32);
      height_r <= REG_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && (in_ch.command == CMD_QUERY)
            && ({1'b0, in_ch.pixel_col} < width_r)
            && ({1'b0, in_ch.pixel_row} < height_r)
            && (count_r != '0)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx_r == count_r - CNT_W'(1)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (!rvld_r && !busy && !out_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ones   = 5'($countones(cover_bits));
  assign scaled = (13'(ones) << 8) - 13'(ones) + 13'd8;

  always_comb begin
    count_nxt     = count_r;
    open_nxt      = open_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    alpha_nxt     = alpha_r;
    status_nxt    = status_r;
    rvld_nxt      = 1'b0;
    rfirst_nxt    = 1'b0;
    rclose_nxt    = 1'b0;
    we            = 1'b0;
    clr           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          alpha_nxt     = '0;
          status_nxt    = STAT_OK;
          unique case (in_ch.command)
            CMD_CLEAR: begin
              count_nxt = '0;
              open_nxt  = 1'b0;
            end
            CMD_START: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                open_nxt  = 1'b1;
              end
            end
            CMD_LINE: begin
              if (!open_r) begin
                status_nxt = STAT_NO_PATH;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if (({1'b0, in_ch.pixel_col} >= width_r)
                  || ({1'b0, in_ch.pixel_row} >= height_r)) begin
                status_nxt = STAT_OFF;
              end else if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                clr           = 1'b1;
                idx_nxt       = '0;
              end
            end
            default: status_nxt = STAT_OK;
          endcase
        end
      end
      ST_WALK: begin
        rvld_nxt   = 1'b1;
        rfirst_nxt = (idx_r == '0);
        idx_nxt    = idx_r + CNT_W'(1);
      end
      ST_CLOSE: begin
        rvld_nxt   = 1'b1;
        rclose_nxt = 1'b1;
      end
      ST_DRAIN: begin
        if (!rvld_r && !busy && !out_valid_r) begin
          out_valid_nxt = 1'b1;
          alpha_nxt     = scaled[11:4] | {8{scaled[12]}};
          status_nxt    = STAT_OK;
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= rvld_nxt;
    end
    idx_r    <= idx_nxt;
    alpha_r  <= alpha_nxt;
    status_r <= status_nxt;
    rfirst_r <= rfirst_nxt;
    rclose_r <= rclose_nxt;
    if (take) begin
      col_r <= in_ch.pixel_col;
      row_r <= in_ch.pixel_row;
    end
  end

  assign wdata.mark = (in_ch.command == CMD_START);
  assign wdata.x    = in_ch.point_x;
  assign wdata.y    = in_ch.point_y;

  eopc_vstore u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign tok.vld   = rvld_r;
  assign tok.first = rfirst_r;
  assign tok.close = rclose_r;
  assign tok.v     = rdata;

  eopc_edge u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .tok        (tok),
    .col        (col_r),
    .row        (row_r),
    .busy       (busy),
    .cover_bits (cover_bits)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.alpha  = alpha_r;
  assign out_ch.status = status_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERT))
    else $error("vertex count beyond store size");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (alpha_r != '0) |-> (status_r == STAT_OK))
    else $error("nonzero alpha with error status");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !out_valid_r && !we)
    else $error("store written or result shown during a query walk");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (idx_r < count_r))
    else $error("walk read past the stored vertices");

endmodule

/* src/eopc_vstore.sv */
// ----------------------------------------------------------------------------
// eopc_vstore: vertex store
// Single-port-write, single-port-read memory of vertices with subpath marks.
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module eopc_vstore
  import eopc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  vert_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output vert_t             rdata
);

  vert_t mem [MAX_VERT];
  vert_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/eopc_edge.sv */
// ----------------------------------------------------------------------------
// eopc_edge: edge crossing pipeline
// Forms edges from the vertex stream, tests each edge against all sixteen
// subsamples of the pixel and toggles their inside bits.
// ----------------------------------------------------------------------------
module eopc_edge
  import eopc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  tok_t             tok,
  input  logic [PIX_W-1:0] col,
  input  logic [PIX_W-1:0] row,
  output logic             busy,
  output logic [NSAMP-1:0] cover_bits
);

  localparam int D_W  = COORD_W + 1;
  localparam int O_W  = COORD_W + 2;

  logic signed [COORD_W-1:0] fx_r, fy_r, px_r, py_r;
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic                      a_vld_r;
  logic                      b_vld_r, c_vld_r, d_vld_r;
  logic signed [D_W-1:0]     dxe_b_r, dye_b_r, dxe_c_r, dye_c_r;
  logic signed [O_W-1:0]     dy0_r, dx0_r;
  logic [SUB-1:0]            up_b_r, dn_b_r, up_c_r, dn_c_r, up_d_r, dn_d_r;
  logic signed [PROD_W-1:0]  lhs0_r, rhs0_r;
  logic signed [PROD_W-1:0]  lhs_r [SUB];
  logic signed [PROD_W-1:0]  rhs_r [SUB];
  logic [NSAMP-1:0]          inside_r;

  logic signed [O_W-1:0]     yl [SUB];
  logic signed [O_W-1:0]     yl0, xs0;
  logic [SUB-1:0]            up_nxt, dn_nxt;
  logic signed [PROD_W-1:0]  mx [SUB];
  logic signed [PROD_W-1:0]  my [SUB];
  logic [NSAMP-1:0]          hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= tok.vld && (tok.close || !tok.first);
    end
    if (tok.vld) begin
      if (tok.close) begin
        ax_r <= px_r;
        ay_r <= py_r;
        bx_r <= fx_r;
        by_r <= fy_r;
      end else if (tok.first) begin
        fx_r <= tok.v.x;
        fy_r <= tok.v.y;
        px_r <= tok.v.x;
        py_r <= tok.v.y;
      end else begin
        ax_r <= px_r;
        ay_r <= py_r;
        bx_r <= tok.v.mark ? fx_r : tok.v.x;
        by_r <= tok.v.mark ? fy_r : tok.v.y;
        px_r <= tok.v.x;
        py_r <= tok.v.y;
        if (tok.v.mark) begin
          fx_r <= tok.v.x;
          fy_r <= tok.v.y;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SUB; j++) begin
      yl[j] = O_W'({row, 2'(j), 8'h80});
      up_nxt[j] = (O_W'(ay_r) <= yl[j]) && (O_W'(by_r) > yl[j]);
      dn_nxt[j] = (O_W'(by_r) <= yl[j]) && (O_W'(ay_r) > yl[j]);
    end
    yl0 = O_W'({row, 2'b00, 8'h80});
    xs0 = O_W'({col, 2'b00, 8'h80});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
    dxe_b_r <= D_W'(bx_r) - D_W'(ax_r);
    dye_b_r <= D_W'(by_r) - D_W'(ay_r);
    dy0_r   <= yl0 - O_W'(ay_r);
    dx0_r   <= xs0 - O_W'(ax_r);
    up_b_r  <= up_nxt;
    dn_b_r  <= dn_nxt;

    lhs0_r  <= PROD_W'(dy0_r) * PROD_W'(dxe_b_r);
    rhs0_r  <= PROD_W'(dx0_r) * PROD_W'(dye_b_r);
    dxe_c_r <= dxe_b_r;
    dye_c_r <= dye_b_r;
    up_c_r  <= up_b_r;
    dn_c_r  <= dn_b_r;

    for (int j = 0; j < SUB; j++) begin
      lhs_r[j] <= lhs0_r + mx[j];
      rhs_r[j] <= rhs0_r + my[j];
    end
    up_d_r <= up_c_r;
    dn_d_r <= dn_c_r;
  end

  always_comb begin
    mx[0] = '0;
    my[0] = '0;
    mx[1] = PROD_W'(dxe_c_r) <<< 8;
    my[1] = PROD_W'(dye_c_r) <<< 8;
    mx[2] = PROD_W'(dxe_c_r) <<< 9;
    my[2] = PROD_W'(dye_c_r) <<< 9;
    mx[3] = mx[1] + mx[2];
    my[3] = my[1] + my[2];
  end

  always_comb begin
    for (int j = 0; j < SUB; j++) begin
      for (int k = 0; k < SUB; k++) begin
        hit[j*SUB+k] = (up_d_r[j] && (lhs_r[j] <= rhs_r[k]))
                    || (dn_d_r[j] && (lhs_r[j] >= rhs_r[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      inside_r <= '0;
    end else if (d_vld_r) begin
      inside_r <= inside_r ^ hit;
    end
  end

  assign busy       = a_vld_r || b_vld_r || c_vld_r || d_vld_r;
  assign cover_bits = inside_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> $past(c_vld_r))
    else $error("edge pipeline lost its ordering");
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(d_vld_r) && !$past(clr) |-> $stable(inside_r))
    else $error("inside bits changed without an edge");
  assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> !((up_nxt & dn_nxt) != '0))
    else $error("edge both rising and falling on one row");

endmodule

/* tb/eopc_test_if.sv */
// ----------------------------------------------------------------------------
// eopc_test_if: channel interfaces seen by the bench
// The bench instantiates the command and result interfaces of the block
// itself, so this file declares nothing of its own.
// ----------------------------------------------------------------------------

/* tb/even_odd_polygon_coverage_test.sv */
// ----------------------------------------------------------------------------
// even_odd_polygon_coverage_test: self-checking bench for polygon coverage
// Drives clear, start, line and query commands with random gaps, predicts the
// alpha and status of every transfer and compares them in transfer order.
// ----------------------------------------------------------------------------
module even_odd_polygon_coverage_test;
  import eopc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] alpha;
    logic [1:0] status;
  } cover_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [REG_W-1:0] cfg_wdata = '0;

  eopc_in_if in_ch ();
  eopc_out_if out_ch ();

  even_odd_polygon_coverage uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  logic signed [COORD_W-1:0] vx_mem [MAX_VERT];
  logic signed [COORD_W-1:0] vy_mem [MAX_VERT];
  logic mark_mem [MAX_VERT];
  int unsigned n_vert;
  bit path_open;
  int unsigned fw, fh;
  cover_t expected_q [$];
  int unsigned errors, results_seen, queries_sent, hold_cycles;
  bit drain_hold;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_CLEAR;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.pixel_col = '0;
    in_ch.pixel_row = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] coverage_alpha(int unsigned col, int unsigned row);
    bit smp [SUB][SUB];
    int unsigned first, nx, cnt;
    longint ax, ay, bx, by, dx, dy, yl, sx, lhs, rhs;
    bit up, down, hit;
    first = 0;
    cnt = 0;
    foreach (smp[a, b]) smp[a][b] = 0;
    for (int unsigned i = 0; i < n_vert; i++) begin
      if (mark_mem[i]) first = i;
      nx = (i + 1 < n_vert && !mark_mem[i + 1]) ? i + 1 : first;
      ax = vx_mem[i];
      ay = vy_mem[i];
      bx = vx_mem[nx];
      by = vy_mem[nx];
      dx = bx - ax;
      dy = by - ay;
      for (int j = 0; j < SUB; j++) begin
        yl = longint'(SUB * row + j) * 256 + 128;
        up = (ay <= yl) && (by > yl);
        down = (by <= yl) && (ay > yl);
        if (up || down) begin
          lhs = (yl - ay) * dx;
          for (int k = 0; k < SUB; k++) begin
            sx = longint'(SUB * col + k) * 256 + 128;
            rhs = (sx - ax) * dy;
            hit = up ? (lhs <= rhs) : (lhs >= rhs);
            if (hit) smp[j][k] ^= 1'b1;
          end
        end
      end
    end
    foreach (smp[a, b]) cnt += smp[a][b];
    return 8'((cnt * 255 + 8) / 16);
  endfunction

  function automatic cover_t predict_coverage(cmd_t c, logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              int unsigned col, int unsigned row);
    cover_t r;
    r = '{alpha: 8'd0, status: STAT_OK};
    case (c)
      CMD_CLEAR: begin
        n_vert = 0;
        path_open = 0;
      end
      CMD_START, CMD_LINE: begin
        if (c == CMD_LINE && !path_open) r.status = STAT_NO_PATH;
        else if (n_vert >= MAX_VERT) r.status = STAT_FULL;
        else begin
          vx_mem[n_vert] = x;
          vy_mem[n_vert] = y;
          mark_mem[n_vert] = (c == CMD_START);
          n_vert++;
          if (c == CMD_START) path_open = 1;
        end
      end
      default: begin
        if (col >= fw || row >= fh) r.status = STAT_OFF;
        else r.alpha = coverage_alpha(col, row);
      end
    endcase
    return r;
  endfunction

  // Valid stays high between back-to-back transfers and drops only for a gap.
  task automatic send_command(cmd_t c, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, int unsigned col,
                              int unsigned row, bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.pixel_col <= PIX_W'(col);
    in_ch.pixel_row <= PIX_W'(row);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q = {expected_q, predict_coverage(c, x, y, col, row)};
    if (c == CMD_QUERY) queries_sent++;
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    stop_input();
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (MAX_VERT + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= REG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) fw = val;
    else fh = val;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    cover_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{alpha: out_ch.alpha, status: out_ch.status};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result alpha=%0d status=%0d",
                                   got.alpha, got.status);
      end else begin
        want = expected_q.pop_front();
        if (got.alpha !== want.alpha || got.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected alpha=%0d status=%0d, got alpha=%0d status=%0d",
                     want.alpha, want.status, got.alpha, got.status);
        end
      end
    end
  end

  initial begin
    int unsigned g;
    @(posedge rst_n);
    forever begin
      if (drain_hold) begin
        out_ch.ready <= 1'b0;
        while (hold_cycles < 300) begin
          @(posedge clk);
          hold_cycles++;
        end
        drain_hold = 0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      g = gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] near_coord(int unsigned span);
    return COORD_W'($signed($urandom_range(0, span * 1024)) - 512);
  endfunction

  task automatic random_polygon(int unsigned nv, int unsigned span);
    send_command(CMD_START, near_coord(span), near_coord(span), 0, 0);
    for (int unsigned i = 1; i < nv; i++)
      send_command(CMD_LINE, near_coord(span), near_coord(span), 0, 0);
  endtask

  task automatic random_query(int unsigned span);
    send_command(CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom),
                 $urandom_range(0, span), $urandom_range(0, span));
  endtask

  task automatic test_directed();
    logic signed [COORD_W-1:0] mx, mn;
    mx = {1'b0, {(COORD_W-1){1'b1}}};
    mn = {1'b1, {(COORD_W-1){1'b0}}};
    send_command(CMD_LINE, 21'sd100, 21'sd100, 0, 0);
    send_command(CMD_QUERY, '0, '0, 0, 0);
    send_command(CMD_START, 21'sd0, 21'sd0, 0, 0);
    send_command(CMD_LINE, 21'sd2048, 21'sd0, 0, 0);
    send_command(CMD_LINE, 21'sd2048, 21'sd2048, 0, 0);
    send_command(CMD_LINE, 21'sd0, 21'sd2048, 0, 0);
    send_command(CMD_QUERY, '0, '0, 0, 0);
    send_command(CMD_QUERY, '0, '0, 1, 1);
    send_command(CMD_QUERY, '0, '0, 2, 0);
    send_command(CMD_QUERY, mx, mn, 31, 31);
    send_command(CMD_QUERY, '0, '0, 32, 0);
    send_command(CMD_QUERY, '0, '0, 0, 255);
    send_command(CMD_START, 21'sd300, 21'sd300, 0, 0);
    send_command(CMD_START, mn, mx, 0, 0);
    send_command(CMD_LINE, mx, mn, 0, 0);
    send_command(CMD_LINE, mx, mx, 0, 0);
    send_command(CMD_LINE, mn, mn, 0, 0);
    send_command(CMD_QUERY, '0, '0, 0, 0);
    send_command(CMD_QUERY, '0, '0, 5, 7);
    send_command(CMD_CLEAR, mx, mx, 255, 255);
    send_command(CMD_LINE, 21'sd1, 21'sd1, 0, 0);
    send_command(CMD_QUERY, '0, '0, 0, 0);
  endtask

  task automatic test_full_store();
    send_command(CMD_CLEAR, '0, '0, 0, 0);
    random_polygon(MAX_VERT, 8);
    send_command(CMD_LINE, 21'sd5, 21'sd5, 0, 0);
    send_command(CMD_START, 21'sd5, 21'sd5, 0, 0);
    repeat (4) random_query(9);
    send_command(CMD_CLEAR, '0, '0, 0, 0);
  endtask

  task automatic test_config();
    int unsigned w [4] = '{4, 256, 0, 511};
    int unsigned h [4] = '{256, 4, 511, 0};
    send_command(CMD_CLEAR, '0, '0, 0, 0);
    random_polygon(6, 40);
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_reg(REG_WIDTH, w[k]);
      write_reg(REG_HEIGHT, h[k]);
      for (int q = 0; q < 10; q++) random_query(255);
      send_command(CMD_QUERY, '0, '0, 3, 3);
      send_command(CMD_QUERY, '0, '0, 255, 255);
    end
    wait_idle();
    write_reg(REG_WIDTH, 32);
    write_reg(REG_HEIGHT, 32);
  endtask

  task automatic test_backpressure();
    send_command(CMD_CLEAR, '0, '0, 0, 0);
    random_polygon(4, 30);
    hold_cycles = 0;
    drain_hold = 1;
    for (int q = 0; q < 20; q++)
      send_command(CMD_QUERY, '0, '0, $urandom_range(0, 31), $urandom_range(0, 31), 1);
  endtask

  task automatic test_random();
    int unsigned sent, r, nv;
    sent = 0;
    while (sent < 1400) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) < 7) send_command(CMD_CLEAR, '0, '0, 0, 0);
        nv = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
        random_polygon(nv, 40);
        sent += nv + 1;
        for (int q = $urandom_range(1, 6); q > 0; q--) begin
          random_query(34);
          sent++;
        end
      end else begin
        send_command(cmd_t'($urandom_range(0, 3)), COORD_W'($urandom),
                     COORD_W'($urandom), $urandom_range(0, 255), $urandom_range(0, 255));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned guard;
    fw = 32;
    fh = 32;
    n_vert = 0;
    path_open = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_config();
    test_backpressure();
    test_random();
    stop_input();
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (MAX_VERT + 20) @(posedge clk);
    $display("Covered %0d results including %0d pixel queries, full store, frame limits",
             results_seen, queries_sent);
    $display("and a long receiver stall; %0d mismatches.", errors);
    if (errors == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
